// ===== hw/rtl/ched_pkg.sv =====
// Shared types and constants for the complex Horner evaluator / deflater.
// No dependencies; used by every module of the block.
package ched_pkg;

  // Command kinds, same encoding as the opcode field
  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_WRITE   = 2'd1,
    OP_EVAL    = 2'd2,
    OP_DEFLATE = 2'd3
  } op_t;

  // Input item as seen on the command channel
  typedef struct packed {
    logic [1:0]         opcode;
    logic [4:0]         index;
    logic signed [31:0] arg_re;
    logic signed [31:0] arg_im;
  } cmd_t;

  // Result item
  typedef struct packed {
    logic signed [31:0] value_re;
    logic signed [31:0] value_im;
    logic               overflow;
    logic [4:0]         degree_after;
  } res_t;

  // Classified command held in the queue; idx is already clamped for OP_CLEAR
  typedef struct packed {
    op_t                kind;
    logic [4:0]         idx;
    logic signed [31:0] arg_re;
    logic signed [31:0] arg_im;
  } item_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam logic [QUEUE_AW:0] QUEUE_FULL = (QUEUE_AW + 1)'(QUEUE_DEPTH);

endpackage

// ===== hw/rtl/ched_front.sv =====
// Front stage: accepts command items, classifies them and feeds the queue.
// Depends on ched_pkg.
module ched_front #(
  parameter int MAX_DEGREE = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  ched_pkg::cmd_t  cmd,
  output logic            push,
  output ched_pkg::item_t push_item,
  input  logic            push_ready
);

  logic            held;
  ched_pkg::item_t held_item;
  ched_pkg::item_t dec;
  logic            over;
  logic            keep;

  always_comb begin
    over          = 32'(cmd.index) > 32'(MAX_DEGREE);
    dec.kind      = ched_pkg::op_t'(cmd.opcode);
    dec.idx       = cmd.index;
    dec.arg_re    = cmd.arg_re;
    dec.arg_im    = cmd.arg_im;
    // saturate an oversized degree
    if (dec.kind == ched_pkg::OP_CLEAR && over) begin
      dec.idx = 5'(MAX_DEGREE);
    end
    // drop writes beyond the store
    keep = !(dec.kind == ched_pkg::OP_WRITE && over);
  end

  assign cmd_stall = held && !push_ready;
  assign push      = held;
  assign push_item = held_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (cmd_valid && !cmd_stall) begin
      held <= keep;
    end else if (push_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      held_item <= dec;
    end
  end

endmodule

// ===== hw/rtl/ched_queue.sv =====
// Short command queue between the front stage and the Horner engine.
// Depends on ched_pkg.
module ched_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ched_pkg::item_t push_item,
  output logic            push_ready,
  output logic            pop_valid,
  output ched_pkg::item_t pop_item,
  input  logic            pop
);

  ched_pkg::item_t                  slots [ched_pkg::QUEUE_DEPTH];
  logic [ched_pkg::QUEUE_AW-1:0]    wr_ptr;
  logic [ched_pkg::QUEUE_AW-1:0]    rd_ptr;
  logic [ched_pkg::QUEUE_AW:0]      count;
  logic                             do_push;
  logic                             do_pop;

  assign push_ready = count != ched_pkg::QUEUE_FULL;
  assign pop_valid  = count != '0;
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_item;
  end

endmodule

// ===== hw/rtl/ched_back.sv =====
// Back end: coefficient store, complex Horner engine and result register.
// Depends on ched_pkg.
module ched_back #(
  parameter int MAX_DEGREE = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  ched_pkg::item_t q_item,
  output logic            q_pop,
  output logic            res_valid,
  input  logic            res_stall,
  output ched_pkg::res_t  res
);

  localparam int DEPTH = MAX_DEGREE + 1;
  localparam int DW    = $clog2(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_ADD  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t             state;
  logic [DW-1:0]      deg;
  logic [DW-1:0]      step;
  logic               deflate;
  logic               ovf;
  logic signed [31:0] x_re;
  logic signed [31:0] x_im;
  logic signed [31:0] acc_re;
  logic signed [31:0] acc_im;
  logic signed [47:0] prod_rr;
  logic signed [47:0] prod_ii;
  logic signed [47:0] prod_ri;
  logic signed [47:0] prod_ir;

  logic [63:0]        mem [DEPTH];
  logic [DEPTH-1:0]   vld;
  logic [63:0]        rd_data;
  logic               rd_vld;

  logic               mem_we;
  logic [DW-1:0]      mem_wa;
  logic [63:0]        mem_wd;
  logic               mem_re;
  logic [DW-1:0]      mem_ra;

  logic signed [63:0] m_rr;
  logic signed [63:0] m_ii;
  logic signed [63:0] m_ri;
  logic signed [63:0] m_ir;
  logic [31:0]        c_re;
  logic [31:0]        c_im;
  logic [49:0]        sum_re;
  logic [49:0]        sum_im;
  logic               ovf_re;
  logic               ovf_im;
  logic [31:0]        sat_re;
  logic [31:0]        sat_im;
  logic [DW-1:0]      deg_new;
  logic               res_load;

  function automatic logic [31:0] clip(input logic [49:0] v);
    if (&v[49:31] || ~|v[49:31]) return v[31:0];
    return v[49] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  function automatic logic clipped(input logic [49:0] v);
    return !(&v[49:31] || ~|v[49:31]);
  endfunction

  assign q_pop = (state == S_IDLE) && q_valid;

  // store port selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = step;
    mem_wd = {acc_im, acc_re};
    mem_re = 1'b0;
    mem_ra = deg;
    case (state)
      S_IDLE: begin
        if (q_valid && q_item.kind == ched_pkg::OP_WRITE) begin
          mem_we = 1'b1;
          mem_wa = DW'(q_item.idx);
          mem_wd = {q_item.arg_im, q_item.arg_re};
        end
        if (q_valid && (q_item.kind == ched_pkg::OP_EVAL ||
                        q_item.kind == ched_pkg::OP_DEFLATE)) begin
          mem_re = 1'b1;
        end
      end
      S_MUL: begin
        // quotient coefficient is the accumulator before this step
        mem_we = deflate;
      end
      S_ADD: begin
        mem_re = step != '0;
        mem_ra = step - 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) begin
      rd_data <= mem[mem_ra];
      rd_vld  <= vld[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (q_pop && q_item.kind == ched_pkg::OP_CLEAR) begin
      vld <= '0;
    end else if (mem_we) begin
      vld[mem_wa] <= 1'b1;
    end
  end

  // datapath
  always_comb begin
    m_rr   = acc_re * x_re;
    m_ii   = acc_im * x_im;
    m_ri   = acc_re * x_im;
    m_ir   = acc_im * x_re;
    c_re   = rd_vld ? rd_data[31:0]  : 32'd0;
    c_im   = rd_vld ? rd_data[63:32] : 32'd0;
    sum_re = {{2{prod_rr[47]}}, prod_rr} - {{2{prod_ii[47]}}, prod_ii}
           + {{18{c_re[31]}}, c_re};
    sum_im = {{2{prod_ri[47]}}, prod_ri} + {{2{prod_ir[47]}}, prod_ir}
           + {{18{c_im[31]}}, c_im};
    sat_re = clip(sum_re);
    sat_im = clip(sum_im);
    ovf_re = clipped(sum_re);
    ovf_im = clipped(sum_im);
    deg_new  = (deflate && deg != '0) ? deg - 1'b1 : deg;
    res_load = (state == S_DONE) && (!res_valid || !res_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      deg   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            case (q_item.kind)
              ched_pkg::OP_CLEAR: deg <= DW'(q_item.idx);
              ched_pkg::OP_WRITE: ;
              default:            state <= S_MUL;
            endcase
          end
        end
        S_MUL: state <= S_ADD;
        S_ADD: state <= (step == '0) ? S_DONE : S_MUL;
        S_DONE: begin
          if (res_load) begin
            deg   <= deg_new;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        step    <= deg;
        deflate <= q_item.kind == ched_pkg::OP_DEFLATE;
        x_re    <= q_item.arg_re;
        x_im    <= q_item.arg_im;
        acc_re  <= '0;
        acc_im  <= '0;
        ovf     <= 1'b0;
      end
      S_MUL: begin
        prod_rr <= m_rr[63:16];
        prod_ii <= m_ii[63:16];
        prod_ri <= m_ri[63:16];
        prod_ir <= m_ir[63:16];
      end
      S_ADD: begin
        acc_re <= sat_re;
        acc_im <= sat_im;
        ovf    <= ovf | ovf_re | ovf_im;
        if (step != '0) step <= step - 1'b1;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res.value_re     <= acc_re;
      res.value_im     <= acc_im;
      res.overflow     <= ovf;
      res.degree_after <= 5'(deg_new);
    end
  end

endmodule

// ===== hw/rtl/complex_horner_eval_deflate_core.sv =====
// Top level of the complex Horner evaluator / root deflater.
// Depends on ched_pkg, ched_front, ched_queue and ched_back.
//
// Usage: commands arrive on the cmd channel (cmd_valid, cmd_stall, cmd), one
// item per accepted edge. Opcode 0 clears the coefficient store and sets the
// degree, opcode 1 writes one coefficient, opcode 2 evaluates p(x), opcode 3
// divides p by (x - root) and returns the remainder. Only opcodes 2 and 3
// produce an item on the res channel (res_valid, res_stall, res).
// The front stage registers and classifies each command, dropping writes
// beyond the store, and places it in a four-entry queue, so commands keep
// flowing while the engine is busy or the result is stalled.
// Clear and write are handled in the idle state. Evaluate and deflate visit
// each of the degree+1 coefficients in two states: S_MUL registers the
// products of four parallel 32x32 multipliers and S_ADD does the saturating
// add. The engine takes no new command until it has handed over the result.
// Reset clears the degree, marks every coefficient as zero, and empties
// the front stage, queue and result register. While res_stall is high the
// result holds in its register and the engine waits to hand over the next
// one; the queue then fills and cmd_stall rises.
module complex_horner_eval_deflate_core #(
  parameter int MAX_DEGREE = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  ched_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_stall,
  output ched_pkg::res_t res
);

  logic            push;
  logic            push_ready;
  ched_pkg::item_t push_item;
  logic            q_valid;
  logic            q_pop;
  ched_pkg::item_t q_item;

  // classify and hold one command
  ched_front #(.MAX_DEGREE(MAX_DEGREE)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  // decouple front from engine
  ched_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop        (q_pop)
  );

  // store, Horner engine and result register
  ched_back #(.MAX_DEGREE(MAX_DEGREE)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  // engine never takes from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // reported degree never exceeds the store
  a_degree_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (32'(res.degree_after) <= 32'(MAX_DEGREE)))
    else $error("degree beyond store depth");

  // reset leaves no result and no queued command
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!res_valid && !q_valid))
    else $error("state left after reset");

endmodule
